FILE: hw/rtl/fbp_pkg.sv
// ----------------------------------------------------------------------------
// fbp_pkg: shared types and constants of the back-off pressure tracker
// Beat structs, command codes, failure kind codes, configuration indexes,
// register reset values and the failure trait table.
// ----------------------------------------------------------------------------
package fbp_pkg;

  localparam int TIME_BITS    = 48;
  localparam int ATTEMPT_BITS = 32;
  localparam int MS_BITS      = 24;
  localparam int KIND_BITS    = 4;
  localparam int COUNT_BITS   = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int TRAIT_BITS   = 6;

  typedef enum logic [1:0] {
    CMD_FAIL  = 2'd0,
    CMD_RELAY = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_PRUNE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST     = 3'd0,
    CFG_SECOND    = 3'd1,
    CFG_MAX       = 3'd2,
    CFG_DNS       = 3'd3,
    CFG_THROTTLED = 3'd4,
    CFG_NOAPP     = 3'd5
  } cfg_idx_t;

  localparam logic [KIND_BITS-1:0] KIND_NONE           = 4'd0;
  localparam logic [KIND_BITS-1:0] KIND_DNS            = 4'd1;
  localparam logic [KIND_BITS-1:0] KIND_HELLO_NO_REPLY = 4'd4;
  localparam logic [KIND_BITS-1:0] KIND_NO_APP_DATA    = 4'd7;
  localparam logic [KIND_BITS-1:0] KIND_SH_NO_PROTO    = 4'd8;
  localparam logic [KIND_BITS-1:0] KIND_CONN_NO_PROTO  = 4'd10;
  localparam logic [KIND_BITS-1:0] KIND_LAST           = 4'd13;

  localparam logic [COUNT_BITS-1:0] COUNT_ONE   = 8'd1;
  localparam logic [COUNT_BITS-1:0] COUNT_TWO   = 8'd2;
  localparam logic [COUNT_BITS-1:0] COUNT_THREE = 8'd3;

  localparam logic [MS_BITS-1:0] FIRST_RESET     = 24'd15000;
  localparam logic [MS_BITS-1:0] SECOND_RESET    = 24'd45000;
  localparam logic [MS_BITS-1:0] MAX_RESET       = 24'd120000;
  localparam logic [MS_BITS-1:0] DNS_RESET       = 24'd30000;
  localparam logic [MS_BITS-1:0] THROTTLED_RESET = 24'd3000;
  localparam logic [MS_BITS-1:0] NOAPP_RESET     = 24'd3000;

  localparam logic [TRAIT_BITS-1:0] T_NEED  = 6'b000001;
  localparam logic [TRAIT_BITS-1:0] T_ROUTE = 6'b000010;
  localparam logic [TRAIT_BITS-1:0] T_ESC   = 6'b000100;
  localparam logic [TRAIT_BITS-1:0] T_ROT   = 6'b001000;
  localparam logic [TRAIT_BITS-1:0] T_INV   = 6'b010000;
  localparam logic [TRAIT_BITS-1:0] T_STALE = 6'b100000;

  localparam logic [TRAIT_BITS-1:0] TRAIT_TABLE [16] = '{
    6'b000000,
    T_NEED,
    T_ROUTE | T_STALE,
    T_ROUTE | T_STALE,
    T_NEED | T_ESC | T_ROT | T_STALE,
    T_NEED | T_ESC | T_ROT | T_STALE,
    T_NEED | T_ESC | T_ROT | T_STALE,
    T_NEED | T_INV | T_STALE,
    T_NEED | T_INV | T_STALE,
    6'b000000,
    T_NEED | T_INV | T_STALE,
    T_INV | T_STALE,
    6'b000000,
    T_NEED,
    6'b000000,
    6'b000000
  };

  typedef struct packed {
    logic can_be_stale;
    logic invalidates_relay;
    logic rotates_tls;
    logic escalates_recipe;
    logic route_only;
    logic needs_cooldown;
  } traits_t;

  typedef struct packed {
    logic [MS_BITS-1:0] first_cooldown_ms;
    logic [MS_BITS-1:0] second_cooldown_ms;
    logic [MS_BITS-1:0] max_cooldown_ms;
    logic [MS_BITS-1:0] dns_negative_ms;
    logic [MS_BITS-1:0] throttled_retry_ms;
    logic [MS_BITS-1:0] no_app_data_ms;
  } cfg_regs_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [ATTEMPT_BITS-1:0] attempt_id;
    logic [KIND_BITS-1:0]    failure_kind;
    logic [TIME_BITS-1:0]    event_time;
    logic [COUNT_BITS-1:0]   failure_count;
  } in_beat_t;

  typedef struct packed {
    logic                 pressure_active;
    logic [KIND_BITS-1:0] pressure_kind;
    logic [TIME_BITS-1:0] retry_until;
    logic                 updated;
    logic [MS_BITS-1:0]   cooldown_ms;
    logic                 needs_cooldown;
    logic                 route_only;
    logic                 escalates_recipe;
    logic                 rotates_tls;
    logic                 invalidates_relay;
    logic                 can_be_stale;
  } out_beat_t;

  typedef struct packed {
    logic                 active;
    logic [KIND_BITS-1:0] kind;
    logic [TIME_BITS-1:0] hold_end;
    logic                 updated;
  } rec_status_t;

endpackage

FILE: hw/rtl/fbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// fbp_cfg_regs: configuration register file
// Six cooldown registers written through a plain write port.
// ----------------------------------------------------------------------------
module fbp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fbp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fbp_pkg::MS_BITS-1:0]         cfg_wdata,
  output fbp_pkg::cfg_regs_t                  regs
);
  import fbp_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.first_cooldown_ms  <= FIRST_RESET;
      regs_r.second_cooldown_ms <= SECOND_RESET;
      regs_r.max_cooldown_ms    <= MAX_RESET;
      regs_r.dns_negative_ms    <= DNS_RESET;
      regs_r.throttled_retry_ms <= THROTTLED_RESET;
      regs_r.no_app_data_ms     <= NOAPP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST:     regs_r.first_cooldown_ms  <= cfg_wdata;
        CFG_SECOND:    regs_r.second_cooldown_ms <= cfg_wdata;
        CFG_MAX:       regs_r.max_cooldown_ms    <= cfg_wdata;
        CFG_DNS:       regs_r.dns_negative_ms    <= cfg_wdata;
        CFG_THROTTLED: regs_r.throttled_retry_ms <= cfg_wdata;
        CFG_NOAPP:     regs_r.no_app_data_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

FILE: hw/rtl/fbp_lookup.sv
// ----------------------------------------------------------------------------
// fbp_lookup: cooldown ladder lookup
// Selects the cooldown for a failure kind and count.
// ----------------------------------------------------------------------------
module fbp_lookup (
  input  logic [fbp_pkg::KIND_BITS-1:0]  kind,
  input  logic [fbp_pkg::COUNT_BITS-1:0] count,
  input  fbp_pkg::cfg_regs_t             regs,
  output logic [fbp_pkg::MS_BITS-1:0]    cooldown_ms
);
  import fbp_pkg::*;

  always_comb begin
    unique case (kind)
      KIND_DNS:            cooldown_ms = regs.dns_negative_ms;
      KIND_HELLO_NO_REPLY: cooldown_ms = regs.first_cooldown_ms;
      KIND_NO_APP_DATA: begin
        cooldown_ms = (count <= COUNT_THREE) ? regs.no_app_data_ms : regs.first_cooldown_ms;
      end
      KIND_SH_NO_PROTO, KIND_CONN_NO_PROTO: begin
        if (count <= COUNT_ONE) begin
          cooldown_ms = regs.throttled_retry_ms;
        end else if (count == COUNT_TWO) begin
          cooldown_ms = regs.first_cooldown_ms;
        end else begin
          cooldown_ms = regs.second_cooldown_ms;
        end
      end
      default: begin
        if (count <= COUNT_ONE) begin
          cooldown_ms = regs.first_cooldown_ms;
        end else if (count == COUNT_TWO) begin
          cooldown_ms = regs.second_cooldown_ms;
        end else begin
          cooldown_ms = regs.max_cooldown_ms;
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/fbp_record.sv
// ----------------------------------------------------------------------------
// fbp_record: pressure record and its update rules
// Holds the record and computes its next value and the status of one beat.
// ----------------------------------------------------------------------------
module fbp_record (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  fbp_pkg::in_beat_t            beat,
  input  logic [fbp_pkg::MS_BITS-1:0]  fail_cooldown_ms,
  output fbp_pkg::rec_status_t         status
);
  import fbp_pkg::*;

  typedef struct packed {
    logic [ATTEMPT_BITS-1:0] attempt;
    logic [KIND_BITS-1:0]    kind;
    logic [TIME_BITS-1:0]    observed;
    logic [TIME_BITS-1:0]    hold_end;
  } record_t;

  record_t rec_r;
  record_t rec_nxt;

  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] until_new;
  logic                 upd;
  logic                 active;

  assign sum       = (TIME_BITS+1)'(beat.event_time) + (TIME_BITS+1)'(fail_cooldown_ms);
  assign until_new = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  always_comb begin
    rec_nxt = rec_r;
    upd     = 1'b0;
    unique case (beat.cmd)
      CMD_FAIL: begin
        if (beat.attempt_id != '0 && beat.failure_kind != KIND_NONE &&
            beat.failure_kind <= KIND_LAST && beat.event_time != '0 &&
            beat.attempt_id > rec_r.attempt) begin
          if (!(rec_r.hold_end > beat.event_time && until_new < rec_r.hold_end)) begin
            rec_nxt.attempt  = beat.attempt_id;
            rec_nxt.kind     = beat.failure_kind;
            rec_nxt.observed = beat.event_time;
            rec_nxt.hold_end = until_new;
            upd              = 1'b1;
          end
        end
      end
      CMD_RELAY: begin
        if (beat.attempt_id != '0 && beat.event_time != '0 &&
            rec_r.attempt < beat.attempt_id && rec_r.observed <= beat.event_time) begin
          rec_nxt = '0;
          upd     = 1'b1;
        end
      end
      CMD_PRUNE: begin
        if (rec_r.hold_end <= beat.event_time) begin
          rec_nxt = '0;
          upd     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign active = rec_nxt.hold_end > beat.event_time;

  always_comb begin
    status.active   = active;
    status.kind     = active ? rec_nxt.kind : '0;
    status.hold_end = active ? rec_nxt.hold_end : '0;
    status.updated  = upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (fire) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

FILE: hw/rtl/failure_backoff_pressure_tracker.sv
// ----------------------------------------------------------------------------
// failure_backoff_pressure_tracker: back-off pressure record for one endpoint
// Throughput is one beat per cycle while the output is not stalled.
// The record is written as a beat leaves the input register.
// Reset clears the record and both stages and loads the default cooldowns.
// Input register, one pass of lookup and record logic, then a result register.
// ----------------------------------------------------------------------------
module failure_backoff_pressure_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fbp_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fbp_pkg::out_beat_t               out_data,
  input  logic                             cfg_we,
  input  logic [fbp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [fbp_pkg::MS_BITS-1:0]      cfg_wdata
);
  import fbp_pkg::*;

  in_beat_t    s1_data_r;
  logic        s1_valid_r;
  out_beat_t   out_data_r;
  logic        out_valid_r;
  logic        out_load;
  logic        s1_fire;
  cfg_regs_t   regs;
  logic [MS_BITS-1:0] fail_cd;
  logic [MS_BITS-1:0] item_cd;
  traits_t     item_traits;
  rec_status_t status;
  out_beat_t   out_nxt;

  assign out_load = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;

  fbp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  fbp_lookup u_fail_lookup (
    .kind        (s1_data_r.failure_kind),
    .count       (COUNT_ONE),
    .regs        (regs),
    .cooldown_ms (fail_cd)
  );

  fbp_lookup u_item_lookup (
    .kind        (s1_data_r.failure_kind),
    .count       (s1_data_r.failure_count),
    .regs        (regs),
    .cooldown_ms (item_cd)
  );

  assign item_traits = traits_t'(TRAIT_TABLE[s1_data_r.failure_kind]);

  fbp_record u_record (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (s1_fire),
    .beat             (s1_data_r),
    .fail_cooldown_ms (fail_cd),
    .status           (status)
  );

  always_comb begin
    out_nxt.pressure_active   = status.active;
    out_nxt.pressure_kind     = status.kind;
    out_nxt.retry_until       = status.hold_end;
    out_nxt.updated           = status.updated;
    out_nxt.cooldown_ms       = item_cd;
    out_nxt.needs_cooldown    = item_traits.needs_cooldown;
    out_nxt.route_only        = item_traits.route_only;
    out_nxt.escalates_recipe  = item_traits.escalates_recipe;
    out_nxt.rotates_tls       = item_traits.rotates_tls;
    out_nxt.invalidates_relay = item_traits.invalidates_relay;
    out_nxt.can_be_stale      = item_traits.can_be_stale;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/sv/failure_backoff_pressure_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// failure_backoff_pressure_tracker_tb: self-checking bench for the tracker
// A short table of directed beats runs first. Random beats follow in several
// cooldown settings. A behavioral copy of the record and the cooldown ladder
// predicts results the table leaves open; handshakes idle at random unless calm.
// ----------------------------------------------------------------------------
module failure_backoff_pressure_tracker_tb;
  import fbp_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_CAP = 100;

  localparam logic [KIND_BITS-1:0] K_TCP_TIMEOUT    = 4'd2;
  localparam logic [KIND_BITS-1:0] K_NO_HELLO_WRITE = 4'd3;
  localparam logic [KIND_BITS-1:0] K_TLS_ALERT      = 4'd5;
  localparam logic [KIND_BITS-1:0] K_HMAC_MISMATCH  = 4'd6;
  localparam logic [KIND_BITS-1:0] K_REMOTE_CLOSED  = 4'd9;
  localparam logic [KIND_BITS-1:0] K_RECV_TIMEOUT   = 4'd11;
  localparam logic [KIND_BITS-1:0] K_UNUSED         = 4'd15;

  typedef enum int {SET_ZERO, SET_FULL, SET_RANDOM, SET_SHORT} cfg_style_t;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  out_beat_t out_data;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [MS_BITS-1:0] cfg_wdata;

  logic [MS_BITS-1:0] cool_ms [6];
  logic [ATTEMPT_BITS-1:0] rec_attempt;
  logic [KIND_BITS-1:0] rec_kind;
  logic [TIME_BITS-1:0] rec_observed;
  logic [TIME_BITS-1:0] rec_until;

  out_beat_t pressure_due [$];
  dir_row_t dir_rows [$];
  logic [TIME_BITS-1:0] now_ms;
  logic [ATTEMPT_BITS-1:0] last_attempt;
  bit calm;
  int mismatches;
  int results_seen;
  int stall_cycles;

  failure_backoff_pressure_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [MS_BITS-1:0] ladder_ms(logic [KIND_BITS-1:0] kind,
                                                   logic [COUNT_BITS-1:0] count);
    case (kind)
      KIND_DNS: return cool_ms[CFG_DNS];
      KIND_HELLO_NO_REPLY: return cool_ms[CFG_FIRST];
      KIND_NO_APP_DATA: return (count <= COUNT_THREE) ? cool_ms[CFG_NOAPP] : cool_ms[CFG_FIRST];
      KIND_SH_NO_PROTO, KIND_CONN_NO_PROTO: begin
        if (count <= COUNT_ONE) return cool_ms[CFG_THROTTLED];
        return (count == COUNT_TWO) ? cool_ms[CFG_FIRST] : cool_ms[CFG_SECOND];
      end
      default: begin
        if (count <= COUNT_ONE) return cool_ms[CFG_FIRST];
        return (count == COUNT_TWO) ? cool_ms[CFG_SECOND] : cool_ms[CFG_MAX];
      end
    endcase
  endfunction

  function automatic logic [TRAIT_BITS-1:0] kind_traits(logic [KIND_BITS-1:0] kind);
    case (kind)
      KIND_DNS, KIND_LAST: return T_NEED;
      K_TCP_TIMEOUT, K_NO_HELLO_WRITE: return T_ROUTE | T_STALE;
      KIND_HELLO_NO_REPLY, K_TLS_ALERT, K_HMAC_MISMATCH: return T_NEED | T_ESC | T_ROT | T_STALE;
      KIND_NO_APP_DATA, KIND_SH_NO_PROTO, KIND_CONN_NO_PROTO: return T_NEED | T_INV | T_STALE;
      K_RECV_TIMEOUT: return T_INV | T_STALE;
      default: return '0;
    endcase
  endfunction

  function automatic out_beat_t status_beat(logic act, logic [KIND_BITS-1:0] kind,
                                            logic [TIME_BITS-1:0] retry, logic upd,
                                            logic [MS_BITS-1:0] cd, logic [TRAIT_BITS-1:0] tr);
    out_beat_t r;
    r.pressure_active   = act;
    r.pressure_kind     = kind;
    r.retry_until       = retry;
    r.updated           = upd;
    r.cooldown_ms       = cd;
    r.needs_cooldown    = |(tr & T_NEED);
    r.route_only        = |(tr & T_ROUTE);
    r.escalates_recipe  = |(tr & T_ESC);
    r.rotates_tls       = |(tr & T_ROT);
    r.invalidates_relay = |(tr & T_INV);
    r.can_be_stale      = |(tr & T_STALE);
    return r;
  endfunction

  function automatic void clear_record();
    rec_attempt  = '0;
    rec_kind     = KIND_NONE;
    rec_observed = '0;
    rec_until    = '0;
  endfunction

  function automatic out_beat_t predict_pressure(in_beat_t b);
    logic [TIME_BITS:0] sum;
    logic [TIME_BITS-1:0] retry;
    logic upd;
    logic act;
    upd = 1'b0;
    case (b.cmd)
      CMD_FAIL: begin
        if (b.attempt_id != '0 && b.failure_kind != KIND_NONE && b.failure_kind <= KIND_LAST &&
            b.event_time != '0 && b.attempt_id > rec_attempt) begin
          sum = {1'b0, b.event_time} + ladder_ms(b.failure_kind, COUNT_ONE);
          retry = sum[TIME_BITS] ? TIME_TOP : sum[TIME_BITS-1:0];
          if (!(rec_until > b.event_time && retry < rec_until)) begin
            rec_attempt  = b.attempt_id;
            rec_kind     = b.failure_kind;
            rec_observed = b.event_time;
            rec_until    = retry;
            upd = 1'b1;
          end
        end
      end
      CMD_RELAY: begin
        if (b.attempt_id != '0 && b.event_time != '0 && rec_attempt < b.attempt_id &&
            rec_observed <= b.event_time) begin
          clear_record();
          upd = 1'b1;
        end
      end
      CMD_PRUNE: begin
        if (rec_until <= b.event_time) begin
          clear_record();
          upd = 1'b1;
        end
      end
      default: ;
    endcase
    act = rec_until > b.event_time;
    return status_beat(act, act ? rec_kind : KIND_NONE, act ? rec_until : '0, upd,
                       ladder_ms(b.failure_kind, b.failure_count), kind_traits(b.failure_kind));
  endfunction

  function automatic void add_row(cmd_t c, logic [ATTEMPT_BITS-1:0] a, logic [KIND_BITS-1:0] k,
                                  logic [TIME_BITS-1:0] t, logic [COUNT_BITS-1:0] n,
                                  bit typed, out_beat_t want);
    dir_row_t r;
    r.beat.cmd           = c;
    r.beat.attempt_id    = a;
    r.beat.failure_kind  = k;
    r.beat.event_time    = t;
    r.beat.failure_count = n;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int roll;
    b.failure_count = ($urandom_range(0, 3) == 0) ? COUNT_BITS'($urandom)
                                                  : COUNT_BITS'($urandom_range(0, 4));
    if ($urandom_range(0, 99) < 12) begin
      b.cmd          = cmd_t'($urandom_range(0, 3));
      b.attempt_id   = $urandom;
      b.failure_kind = KIND_BITS'($urandom_range(0, 15));
      b.event_time   = {16'($urandom), 32'($urandom)};
      return b;
    end
    case ($urandom_range(0, 3))
      0: now_ms += $urandom_range(0, 20);
      1, 2: now_ms += $urandom_range(0, 4000);
      default: now_ms += $urandom_range(0, 150000);
    endcase
    b.event_time = now_ms;
    b.failure_kind = ($urandom_range(0, 9) == 0) ? KIND_BITS'($urandom_range(0, 15))
                                                 : KIND_BITS'($urandom_range(1, 13));
    b.attempt_id = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      b.cmd = CMD_FAIL;
      if ($urandom_range(0, 4) == 0) begin
        b.attempt_id = last_attempt - $urandom_range(0, 2);
      end else begin
        last_attempt += $urandom_range(1, 3);
        b.attempt_id = last_attempt;
      end
    end else if (roll < 55) begin
      b.cmd = CMD_RELAY;
      b.attempt_id = last_attempt + $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) b.event_time = now_ms - $urandom_range(0, 3000);
    end else if (roll < 80) begin
      b.cmd = CMD_QUERY;
    end else begin
      b.cmd = CMD_PRUNE;
    end
    if ($urandom_range(0, 39) == 0) b.attempt_id = '0;
    if ($urandom_range(0, 39) == 0) b.event_time = '0;
    return b;
  endfunction

  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 36);
  endfunction

  task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch in %s at result %0d: got 0x%0h, want 0x%0h",
               field, results_seen, got, want);
    mismatches++;
  endtask

  task automatic check_result(out_beat_t got, out_beat_t want);
    if (got.pressure_active !== want.pressure_active)
      note_mismatch("pressure_active", got.pressure_active, want.pressure_active);
    if (got.pressure_kind !== want.pressure_kind)
      note_mismatch("pressure_kind", got.pressure_kind, want.pressure_kind);
    if (got.retry_until !== want.retry_until)
      note_mismatch("retry_until", got.retry_until, want.retry_until);
    if (got.updated !== want.updated)
      note_mismatch("updated", got.updated, want.updated);
    if (got.cooldown_ms !== want.cooldown_ms)
      note_mismatch("cooldown_ms", got.cooldown_ms, want.cooldown_ms);
    if (got.needs_cooldown !== want.needs_cooldown)
      note_mismatch("needs_cooldown", got.needs_cooldown, want.needs_cooldown);
    if (got.route_only !== want.route_only)
      note_mismatch("route_only", got.route_only, want.route_only);
    if (got.escalates_recipe !== want.escalates_recipe)
      note_mismatch("escalates_recipe", got.escalates_recipe, want.escalates_recipe);
    if (got.rotates_tls !== want.rotates_tls)
      note_mismatch("rotates_tls", got.rotates_tls, want.rotates_tls);
    if (got.invalidates_relay !== want.invalidates_relay)
      note_mismatch("invalidates_relay", got.invalidates_relay, want.invalidates_relay);
    if (got.can_be_stale !== want.can_be_stale)
      note_mismatch("can_be_stale", got.can_be_stale, want.can_be_stale);
  endtask

  // Called and returns at a falling edge; valid is assigned once per edge.
  task automatic drive_beat(in_beat_t b, bit typed, out_beat_t want);
    out_beat_t predicted;
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_pressure(b);
    pressure_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic run_random(int beats);
    repeat (beats) drive_beat(random_beat(), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pressure_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_cooldowns(cfg_style_t style);
    logic [MS_BITS-1:0] v;
    for (int i = 0; i < 6; i++) begin
      case (style)
        SET_ZERO: v = '0;
        SET_FULL: v = '1;
        SET_RANDOM: v = MS_BITS'($urandom);
        default: v = MS_BITS'($urandom_range(0, 100));
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= v;
      cool_ms[i] = v;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pressure_due.size() == 0) begin
        note_mismatch("unexpected beat", '0, '0);
      end else begin
        check_result(out_data, pressure_due.pop_front());
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_FIRST;
    cfg_wdata = '0;
    calm = 1'b0;
    mismatches = 0;
    results_seen = 0;
    stall_cycles = 0;
    cool_ms[CFG_FIRST]     = FIRST_RESET;
    cool_ms[CFG_SECOND]    = SECOND_RESET;
    cool_ms[CFG_MAX]       = MAX_RESET;
    cool_ms[CFG_DNS]       = DNS_RESET;
    cool_ms[CFG_THROTTLED] = THROTTLED_RESET;
    cool_ms[CFG_NOAPP]     = NOAPP_RESET;
    clear_record();

    // Empty record, then the ignored forms of a failure with a bad field.
    add_row(CMD_QUERY, '0, KIND_NONE, '0, '0, 1'b1,
            status_beat(1'b0, KIND_NONE, '0, 1'b0, FIRST_RESET, '0));
    add_row(CMD_PRUNE, '0, KIND_NONE, '0, '0, 1'b1,
            status_beat(1'b0, KIND_NONE, '0, 1'b1, FIRST_RESET, '0));
    add_row(CMD_FAIL, '0, KIND_DNS, 48'd1000, COUNT_ONE, 1'b1,
            status_beat(1'b0, KIND_NONE, '0, 1'b0, DNS_RESET, T_NEED));
    add_row(CMD_FAIL, 32'd5, KIND_NONE, 48'd1000, COUNT_ONE, 1'b1,
            status_beat(1'b0, KIND_NONE, '0, 1'b0, FIRST_RESET, '0));
    add_row(CMD_FAIL, 32'd5, KIND_DNS, '0, COUNT_ONE, 1'b1,
            status_beat(1'b0, KIND_NONE, '0, 1'b0, DNS_RESET, T_NEED));
    add_row(CMD_FAIL, 32'd5, K_UNUSED, 48'd1000, COUNT_TWO, 1'b1,
            status_beat(1'b0, KIND_NONE, '0, 1'b0, SECOND_RESET, '0));
    // Install, stale attempt, shorter record while live, longer record.
    add_row(CMD_FAIL, 32'd5, KIND_HELLO_NO_REPLY, 48'd1000, COUNT_ONE, 1'b0, '0);
    add_row(CMD_FAIL, 32'd5, K_TCP_TIMEOUT, 48'd2000, COUNT_ONE, 1'b0, '0);
    add_row(CMD_FAIL, 32'd6, KIND_SH_NO_PROTO, 48'd2000, '0, 1'b0, '0);
    add_row(CMD_FAIL, 32'd7, KIND_DNS, 48'd2000, COUNT_ONE, 1'b0, '0);
    add_row(CMD_QUERY, '0, KIND_NONE, 48'd31999, '0, 1'b0, '0);
    add_row(CMD_QUERY, '0, KIND_NONE, 48'd32000, '0, 1'b0, '0);
    // Relay from the same attempt, observed too early, without an id, then a clear.
    add_row(CMD_RELAY, 32'd7, KIND_NONE, 48'd5000, '0, 1'b0, '0);
    add_row(CMD_RELAY, 32'd8, KIND_NONE, 48'd1000, '0, 1'b0, '0);
    add_row(CMD_RELAY, '0, KIND_NONE, 48'd5000, '0, 1'b0, '0);
    add_row(CMD_RELAY, 32'd8, KIND_NONE, 48'd2000, '0, 1'b0, '0);
    // Retry time saturates at the top of the time range.
    add_row(CMD_FAIL, 32'd9, KIND_LAST, TIME_TOP - 48'd10, 8'd255, 1'b1,
            status_beat(1'b1, KIND_LAST, TIME_TOP, 1'b1, MAX_RESET, T_NEED));
    add_row(CMD_QUERY, '0, KIND_NONE, TIME_TOP, '0, 1'b1,
            status_beat(1'b0, KIND_NONE, '0, 1'b0, FIRST_RESET, '0));
    add_row(CMD_PRUNE, '0, KIND_NONE, TIME_TOP - 48'd1, '0, 1'b0, '0);
    add_row(CMD_PRUNE, '0, KIND_NONE, TIME_TOP, '0, 1'b1,
            status_beat(1'b0, KIND_NONE, '0, 1'b1, FIRST_RESET, '0));
    add_row(CMD_FAIL, '1, KIND_NO_APP_DATA, 48'd100, COUNT_THREE, 1'b0, '0);
    // Ladder corners by kind and count.
    add_row(CMD_QUERY, '0, KIND_NO_APP_DATA, 48'd200, 8'd4, 1'b0, '0);
    add_row(CMD_QUERY, '0, KIND_CONN_NO_PROTO, 48'd200, COUNT_TWO, 1'b0, '0);
    add_row(CMD_QUERY, '0, KIND_SH_NO_PROTO, 48'd200, COUNT_THREE, 1'b0, '0);
    add_row(CMD_QUERY, '0, K_RECV_TIMEOUT, 48'd200, '0, 1'b0, '0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) drive_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    now_ms = $urandom_range(1, 5000);
    last_attempt = $urandom_range(1, 100);
    run_random(180);

    drain();
    program_cooldowns(SET_ZERO);
    run_random(150);

    drain();
    program_cooldowns(SET_FULL);
    run_random(170);

    drain();
    program_cooldowns(SET_RANDOM);
    calm = 1'b1;
    run_random(180);
    calm = 1'b0;

    drain();
    program_cooldowns(SET_SHORT);
    now_ms = $urandom_range(1, 5000);
    run_random(180);

    // Near the top of both the time and the attempt ranges.
    drain();
    program_cooldowns(SET_RANDOM);
    now_ms = TIME_TOP - $urandom_range(0, 600000);
    last_attempt = 32'hFFFF_FF00 + $urandom_range(0, 200);
    run_random(170);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: failure_backoff_pressure_tracker.f
hw/rtl/fbp_pkg.sv
hw/rtl/fbp_cfg_regs.sv
hw/rtl/fbp_lookup.sv
hw/rtl/fbp_record.sv
hw/rtl/failure_backoff_pressure_tracker.sv
tb/sv/failure_backoff_pressure_tracker_tb.sv
